@@ rtl/hri_pkg.sv @@
package hri_pkg;

  // radix and digit width
  localparam int BASE_BITS = 8;
  localparam int MIN_BASE  = 2;

  typedef logic [BASE_BITS-1:0] digit_t;

  // digit stack command
  typedef struct packed {
    logic push;
    logic pop;
  } stk_cmd_t;

endpackage

@@ rtl/hri_divstep.sv @@
// one restoring division step: bring in one bit, subtract the radix if it fits
module hri_divstep import hri_pkg::*; (
  input  digit_t rem_i,
  input  logic   bit_i,
  input  digit_t base_i,
  output digit_t rem_o,
  output logic   q_o
);

  logic [BASE_BITS:0] trial;
  logic [BASE_BITS:0] diff;

  assign trial = {rem_i, bit_i};
  assign diff  = trial - {1'b0, base_i};
  assign q_o   = (trial >= {1'b0, base_i});
  assign rem_o = q_o ? diff[BASE_BITS-1:0] : trial[BASE_BITS-1:0];

endmodule

@@ rtl/hri_digit_stack.sv @@
// last-in first-out store for the digits of the index
module hri_digit_stack import hri_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  stk_cmd_t cmd,
  input  digit_t   wr_digit,
  output digit_t   rd_digit,
  output logic     empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  digit_t          mem [DEPTH];
  digit_t          rd_r;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;
  logic [CW-1:0]   top_idx;

  assign top_idx  = cnt_r - CW'(1);
  assign rd_digit = rd_r;
  assign empty    = (cnt_r == '0);

  always_comb begin
    priority if (cmd.push) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.pop) begin
      cnt_nxt = top_idx;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[cnt_r[AW-1:0]] <= wr_digit;
    end
    if (cmd.pop) begin
      rd_r <= mem[top_idx[AW-1:0]];
    end
  end

endmodule

@@ rtl/halton_radical_inverse.sv @@
// channel   direction  ports                           transfer
// input     in         in_valid, in_stall, in_index,   in_valid & !in_stall
//                      in_base
// result    out        out_valid, out_stall,           out_valid & !out_stall
//                      out_fraction
//
// One bit-serial divide step sets the pace. Each radix-b digit of the index (one
// digit for a zero index) is peeled off by a bit-serial division by the radix,
// then folded into the fraction bit by bit. A radix below two answers zero at once.
// Reset (rst_n low, synchronous) returns the controller to idle and drops any
// pending result. A stalled result holds in the output register while the next
// item is accepted and worked on; the input stalls while an item is in work.
module halton_radical_inverse import hri_pkg::*; #(
  parameter int INDEX_BITS    = 32,
  parameter int FRACTION_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [INDEX_BITS-1:0]    in_index,
  input  logic [BASE_BITS-1:0]     in_base,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [FRACTION_BITS-1:0] out_fraction
);

  localparam int IW     = $clog2(INDEX_BITS);
  localparam int WB     = $clog2(INDEX_BITS + 1);
  localparam int SC_MAX = (INDEX_BITS > FRACTION_BITS) ? INDEX_BITS : FRACTION_BITS;
  localparam int SCW    = $clog2(SC_MAX + 1);

  // controller states
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for an input transfer
  localparam logic [2:0] S_DIV  = 3'd1;  // peel digits off the index, LSD first
  localparam logic [2:0] S_POP  = 3'd2;  // fetch the most significant digit left
  localparam logic [2:0] S_LOAD = 3'd3;  // seed the remainder with that digit
  localparam logic [2:0] S_ACC  = 3'd4;  // fold the digit into the fraction
  localparam logic [2:0] S_OUT  = 3'd5;  // hand the fraction to the output register

  logic [2:0]               state_r, state_nxt;
  logic [INDEX_BITS-1:0]    val_r, val_nxt;      // shrinking quotient, low wid_r bits live
  logic [FRACTION_BITS-1:0] acc_r, acc_nxt;      // running fraction
  digit_t                   base_r, base_nxt;
  digit_t                   rem_r, rem_nxt;
  logic [WB-1:0]            wid_r, wid_nxt;      // live width of the quotient
  logic [SCW-1:0]           sc_r, sc_nxt;        // steps left in the current division
  logic                     nz_r, nz_nxt;        // quotient has a one bit so far
  logic [FRACTION_BITS-1:0] frac_r, frac_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [WB-1:0]            wid_m1;
  logic                     step_bit;
  logic                     step_q;
  digit_t                   step_rem;
  logic                     last_step;
  logic                     in_xfer;
  logic                     out_free;
  stk_cmd_t                 stk_cmd;
  digit_t                   stk_rd;
  logic                     stk_empty;

  assign in_stall     = (state_r != S_IDLE);
  assign in_xfer      = in_valid & ~in_stall;
  assign out_free     = ~out_valid_r | ~out_stall;
  assign out_valid    = out_valid_r;
  assign out_fraction = frac_r;

  assign wid_m1    = wid_r - WB'(1);
  assign last_step = (sc_r == SCW'(1));

  // The live quotient always keeps its top bit at wid_r-1: each left shift
  // moves the next bit there while the new quotient bit enters at the bottom.
  assign step_bit = (state_r == S_ACC) ? acc_r[FRACTION_BITS-1] : val_r[wid_m1[IW-1:0]];

  hri_divstep u_step (
    .rem_i  (rem_r),
    .bit_i  (step_bit),
    .base_i (base_r),
    .rem_o  (step_rem),
    .q_o    (step_q)
  );

  hri_digit_stack #(
    .DEPTH (INDEX_BITS)
  ) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (stk_cmd),
    .wr_digit (step_rem),
    .rd_digit (stk_rd),
    .empty    (stk_empty)
  );

  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    rem_nxt   = rem_r;
    wid_nxt   = wid_r;
    sc_nxt    = sc_r;
    nz_nxt    = nz_r;
    stk_cmd   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          base_nxt = in_base;
          val_nxt  = in_index;
          acc_nxt  = '0;
          rem_nxt  = '0;
          wid_nxt  = WB'(INDEX_BITS);
          sc_nxt   = SCW'(INDEX_BITS);
          nz_nxt   = 1'b0;
          // radix 0 or 1 has no digits to mirror: answer zero at once
          state_nxt = (in_base < digit_t'(MIN_BASE)) ? S_OUT : S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = step_rem;
        val_nxt = {val_r[INDEX_BITS-2:0], step_q};
        nz_nxt  = nz_r | step_q;
        sc_nxt  = sc_r - SCW'(1);
        if (last_step) begin
          // push the remainder as the next digit; divide again while the quotient is nonzero
          stk_cmd.push = 1'b1;
          rem_nxt      = '0;
          nz_nxt       = 1'b0;
          if (nz_r | step_q) begin
            wid_nxt = wid_m1;
            sc_nxt  = SCW'(wid_m1);
          end else begin
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        stk_cmd.pop = 1'b1;
        state_nxt   = S_LOAD;
      end
      S_LOAD: begin
        // digit < radix, so its own division steps give quotient zero: start here
        rem_nxt   = stk_rd;
        sc_nxt    = SCW'(FRACTION_BITS);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        rem_nxt = step_rem;
        acc_nxt = {acc_r[FRACTION_BITS-2:0], step_q};
        sc_nxt  = sc_r - SCW'(1);
        if (last_step) begin
          state_nxt = stk_empty ? S_OUT : S_POP;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register: load when free or being drained, drop after a transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    frac_nxt      = frac_r;
    priority if (state_r == S_OUT && out_free) begin
      out_valid_nxt = 1'b1;
      frac_nxt      = acc_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    rem_r  <= rem_nxt;
    wid_r  <= wid_nxt;
    sc_r   <= sc_nxt;
    nz_r   <= nz_nxt;
    frac_r <= frac_nxt;
  end

endmodule

@@ rtl/hri_checker.sv @@
module hri_checker import hri_pkg::*; #(
  parameter int FRACTION_BITS = 32
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [FRACTION_BITS-1:0] out_fraction
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fraction))
    else $error("result changed while stalled");

  // an accepted item keeps the input side busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transfer");

  // a new result only appears after the block was busy with an item
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in flight");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind halton_radical_inverse hri_checker #(
  .FRACTION_BITS (FRACTION_BITS)
) u_hri_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_fraction (out_fraction)
);
